[hdl/vns_pkg.sv]
// Package for the vector normalize and scale block.
// Holds the default parameter values and the item kind codes; no dependencies.
`default_nettype none
package vns_pkg;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COMP_WIDTH_DEF = 24;
   localparam int LANES          = 3;

   typedef enum logic {KIND_NORMALIZE = 1'b0, KIND_SCALE = 1'b1} kind_type;
endpackage
`default_nettype wire

[hdl/vns_front.sv]
// Input register, sizes, squares, scale products and clamp.
// Depends on vns_pkg. Three register stages feeding the root chain.
`default_nettype none
module vns_front import vns_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic                    in_kind,
   input  wire logic [COMP_WIDTH-1:0]   in_comp [LANES],
   input  wire logic [COMP_WIDTH-1:0]   in_scale,
   output logic                         out_valid,
   output logic [2*COMP_WIDTH-1:0]      out_sum,
   output logic                         out_kind,
   output logic                         out_sat,
   output logic [LANES-1:0]             out_neg,
   output logic [COMP_WIDTH-1:0]        out_comp [LANES],
   output logic [COMP_WIDTH-1:0]        out_abs [LANES],
   output logic [COMP_WIDTH-1:0]        out_scaled [LANES]
);
   localparam int CW = COMP_WIDTH;
   localparam int PW = 2 * CW;

   logic            v1_ff, v2_ff, v3_ff;
   logic            kind1_ff, kind2_ff, kind3_ff;
   logic [CW-1:0]   comp1_ff [LANES];
   logic [CW-1:0]   comp2_ff [LANES];
   logic [CW-1:0]   comp3_ff [LANES];
   logic [CW-1:0]   scale1_ff;
   logic [CW-1:0]   abs_in [LANES];
   logic [CW-1:0]   abs2_ff [LANES];
   logic [CW-1:0]   abs3_ff [LANES];
   logic [CW-1:0]   kabs;
   logic [LANES-1:0] neg_in, neg2_ff, neg3_ff;
   logic [PW-1:0]   sq2_ff [LANES];
   logic [PW-1:0]   prod2_ff [LANES];
   logic [PW-1:0]   sum_in, sum3_ff;
   logic [CW-1:0]   scaled_in [LANES];
   logic [CW-1:0]   scaled3_ff [LANES];
   logic [LANES-1:0] sat_in;
   logic            sat3_ff;

   always_comb begin
      kabs = scale1_ff[CW-1] ? (~scale1_ff + 1'b1) : scale1_ff;
      for (int i = 0; i < LANES; i++) begin
         abs_in[i] = comp1_ff[i][CW-1] ? (~comp1_ff[i] + 1'b1) : comp1_ff[i];
         neg_in[i] = comp1_ff[i][CW-1] ^ scale1_ff[CW-1];
      end
   end

   always_comb begin
      logic [PW-1:0] m;
      logic [PW-1:0] lim;
      sum_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      for (int i = 0; i < LANES; i++) begin
         m   = prod2_ff[i] >> FRAC_BITS;
         lim = neg2_ff[i] ? (PW'(1) << (CW - 1)) : ((PW'(1) << (CW - 1)) - 1'b1);
         sat_in[i] = m > lim;
         if (sat_in[i]) m = lim;
         scaled_in[i] = neg2_ff[i] ? CW'(~m + 1'b1) : CW'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      kind1_ff  <= in_kind;
      comp1_ff  <= in_comp;
      scale1_ff <= in_scale;
      kind2_ff  <= kind1_ff;
      comp2_ff  <= comp1_ff;
      abs2_ff   <= abs_in;
      neg2_ff   <= neg_in;
      for (int i = 0; i < LANES; i++) begin
         sq2_ff[i]   <= abs_in[i] * abs_in[i];
         prod2_ff[i] <= abs_in[i] * kabs;
      end
      kind3_ff   <= kind2_ff;
      comp3_ff   <= comp2_ff;
      abs3_ff    <= abs2_ff;
      neg3_ff    <= neg2_ff;
      sum3_ff    <= sum_in;
      scaled3_ff <= scaled_in;
      sat3_ff    <= |sat_in;
   end

   assign out_valid  = v3_ff;
   assign out_sum    = sum3_ff;
   assign out_kind   = kind3_ff;
   assign out_sat    = sat3_ff;
   assign out_neg    = neg3_ff;
   assign out_comp   = comp3_ff;
   assign out_abs    = abs3_ff;
   assign out_scaled = scaled3_ff;
endmodule
`default_nettype wire

[hdl/vns_sqrt_cell.sv]
// One digit of the square root: two radicand bits in, one root bit out.
// Depends on vns_pkg. Side data passes through unchanged.
`default_nettype none
module vns_sqrt_cell import vns_pkg::*; #(
   parameter int RW     = COMP_WIDTH_DEF,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [2*RW-1:0]   in_rad,
   input  wire logic [RW+1:0]     in_rem,
   input  wire logic [RW-1:0]     in_root,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [2*RW-1:0]        out_rad,
   output logic [RW+1:0]          out_rem,
   output logic [RW-1:0]          out_root,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [2*RW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]     rem_ff, rem_in, rem_t, trial;
   logic [RW-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic              ge;

   always_comb begin
      rem_t   = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
      trial   = {in_root, 2'b01};
      ge      = rem_t >= trial;
      rem_in  = ge ? (rem_t - trial) : rem_t;
      root_in = {in_root[RW-2:0], ge};
      rad_in  = in_rad << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

[hdl/vns_div_cell.sv]
// One restoring divide step for all three lanes against the magnitude.
// Depends on vns_pkg. Side data passes through unchanged.
`default_nettype none
module vns_div_cell import vns_pkg::*; #(
   parameter int CW     = COMP_WIDTH_DEF,
   parameter int QW     = FRAC_BITS_DEF + 1,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [CW-1:0]     in_mag,
   input  wire logic [CW:0]       in_rem [LANES],
   input  wire logic [QW-1:0]     in_quo [LANES],
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [CW-1:0]          out_mag,
   output logic [CW:0]            out_rem [LANES],
   output logic [QW-1:0]          out_quo [LANES],
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [CW-1:0]     mag_ff;
   logic [CW:0]       rem_ff [LANES];
   logic [CW:0]       rem_in [LANES];
   logic [QW-1:0]     quo_ff [LANES];
   logic [QW-1:0]     quo_in [LANES];
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      logic [CW:0] rs;
      logic        ge;
      for (int i = 0; i < LANES; i++) begin
         ge        = in_rem[i] >= {1'b0, in_mag};
         rs        = ge ? (in_rem[i] - {1'b0, in_mag}) : in_rem[i];
         rem_in[i] = {rs[CW-1:0], 1'b0};
         quo_in[i] = {in_quo[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      mag_ff  <= in_mag;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

[hdl/vector3_normalize_scale.sv]
// Throughput: one item per cycle; busy is always low.
// Pipeline from accept to rsp_valid: three front stages, a chain of COMP_WIDTH root
// cells, a chain of FRAC_BITS+1 divide cells and the output register.
// Reset (synchronous, active high) clears all valid bits; items in flight are dropped.
// Depends on vns_pkg, vns_front, vns_sqrt_cell, vns_div_cell.
`default_nettype none
module vector3_normalize_scale import vns_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_kind,
   input  wire logic [COMP_WIDTH-1:0] req_comp_x,
   input  wire logic [COMP_WIDTH-1:0] req_comp_y,
   input  wire logic [COMP_WIDTH-1:0] req_comp_z,
   input  wire logic [COMP_WIDTH-1:0] req_scale_factor,
   output logic                       rsp_valid,
   output logic [COMP_WIDTH-1:0]      rsp_magnitude,
   output logic [COMP_WIDTH-1:0]      rsp_res_x,
   output logic [COMP_WIDTH-1:0]      rsp_res_y,
   output logic [COMP_WIDTH-1:0]      rsp_res_z,
   output logic                       rsp_zero_length,
   output logic                       rsp_saturated
);
   localparam int CW     = COMP_WIDTH;
   localparam int QW     = FRAC_BITS + 1;
   localparam int NDIV   = FRAC_BITS + 1;
   localparam int SIDE_W = 2 + LANES + 3 * LANES * CW;
   localparam int EW     = CW + QW;

   logic [CW-1:0]     in_comp [LANES];
   logic              f_valid, f_kind, f_sat;
   logic [2*CW-1:0]   f_sum;
   logic [LANES-1:0]  f_neg;
   logic [CW-1:0]     f_comp [LANES];
   logic [CW-1:0]     f_abs [LANES];
   logic [CW-1:0]     f_scaled [LANES];

   logic              s_valid [CW+1];
   logic [2*CW-1:0]   s_rad [CW+1];
   logic [CW+1:0]     s_rem [CW+1];
   logic [CW-1:0]     s_root [CW+1];
   logic [SIDE_W-1:0] s_side [CW+1];

   logic              d_valid [NDIV+1];
   logic [CW-1:0]     d_mag [NDIV+1];
   logic [CW:0]       d_rem [NDIV+1][LANES];
   logic [QW-1:0]     d_quo [NDIV+1][LANES];
   logic [SIDE_W-1:0] d_side [NDIV+1];

   logic              e_kind, e_sat;
   logic [LANES-1:0]  e_neg;
   logic [CW-1:0]     e_comp [LANES];
   logic [CW-1:0]     e_abs [LANES];
   logic [CW-1:0]     e_scaled [LANES];
   logic [CW-1:0]     r_abs [LANES];
   logic [CW-1:0]     res_in [LANES];
   logic              zero_in;

   logic              valid_ff;
   logic [CW-1:0]     mag_ff;
   logic [CW-1:0]     res_ff [LANES];
   logic              zero_ff, sat_ff;

   assign busy       = 1'b0;
   assign in_comp[0] = req_comp_x;
   assign in_comp[1] = req_comp_y;
   assign in_comp[2] = req_comp_z;

   vns_front #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_kind    (req_kind),
      .in_comp    (in_comp),
      .in_scale   (req_scale_factor),
      .out_valid  (f_valid),
      .out_sum    (f_sum),
      .out_kind   (f_kind),
      .out_sat    (f_sat),
      .out_neg    (f_neg),
      .out_comp   (f_comp),
      .out_abs    (f_abs),
      .out_scaled (f_scaled)
   );

   assign s_valid[0] = f_valid;
   assign s_rad[0]   = f_sum;
   assign s_rem[0]   = '0;
   assign s_root[0]  = '0;
   assign s_side[0]  = {f_kind, f_sat, f_neg,
                        f_comp[2], f_comp[1], f_comp[0],
                        f_abs[2], f_abs[1], f_abs[0],
                        f_scaled[2], f_scaled[1], f_scaled[0]};

   for (genvar g = 0; g < CW; g++) begin : g_sqrt
      vns_sqrt_cell #(.RW(CW), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s_valid[g]),
         .in_rad    (s_rad[g]),
         .in_rem    (s_rem[g]),
         .in_root   (s_root[g]),
         .in_side   (s_side[g]),
         .out_valid (s_valid[g+1]),
         .out_rad   (s_rad[g+1]),
         .out_rem   (s_rem[g+1]),
         .out_root  (s_root[g+1]),
         .out_side  (s_side[g+1])
      );
   end

   assign {e_kind, e_sat, e_neg, e_comp[2], e_comp[1], e_comp[0],
           e_abs[2], e_abs[1], e_abs[0],
           e_scaled[2], e_scaled[1], e_scaled[0]} = s_side[CW];

   assign d_valid[0] = s_valid[CW];
   assign d_mag[0]   = s_root[CW];
   assign d_side[0]  = s_side[CW];
   for (genvar i = 0; i < LANES; i++) begin : g_div_in
      assign d_rem[0][i] = {1'b0, e_abs[i]};
      assign d_quo[0][i] = '0;
   end

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      vns_div_cell #(.CW(CW), .QW(QW), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[g]),
         .in_mag    (d_mag[g]),
         .in_rem    (d_rem[g]),
         .in_quo    (d_quo[g]),
         .in_side   (d_side[g]),
         .out_valid (d_valid[g+1]),
         .out_mag   (d_mag[g+1]),
         .out_rem   (d_rem[g+1]),
         .out_quo   (d_quo[g+1]),
         .out_side  (d_side[g+1])
      );
   end

   logic             o_kind, o_sat;
   logic [LANES-1:0] o_neg;
   logic [CW-1:0]    o_comp [LANES];
   logic [CW-1:0]    o_scaled [LANES];

   assign {o_kind, o_sat, o_neg, o_comp[2], o_comp[1], o_comp[0],
           r_abs[2], r_abs[1], r_abs[0],
           o_scaled[2], o_scaled[1], o_scaled[0]} = d_side[NDIV];

   // neg bits hold comp sign xor factor sign; recover comp sign from raw value
   always_comb begin
      logic [EW-1:0] q;
      zero_in = (o_kind == KIND_NORMALIZE) && (d_mag[NDIV] == '0);
      for (int i = 0; i < LANES; i++) begin
         q = EW'(d_quo[NDIV][i]);
         if (o_comp[i][CW-1]) q = ~q + 1'b1;
         if (o_kind == KIND_SCALE) res_in[i] = o_scaled[i];
         else if (zero_in)         res_in[i] = o_comp[i];
         else                      res_in[i] = q[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d_valid[NDIV];
      end
      mag_ff  <= d_mag[NDIV];
      res_ff  <= res_in;
      zero_ff <= zero_in;
      sat_ff  <= (o_kind == KIND_SCALE) && o_sat;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_magnitude   = mag_ff;
   assign rsp_res_x       = res_ff[0];
   assign rsp_res_y       = res_ff[1];
   assign rsp_res_z       = res_ff[2];
   assign rsp_zero_length = zero_ff;
   assign rsp_saturated   = sat_ff;

   logic unused_ok;
   assign unused_ok = ^{e_kind, e_sat, e_neg, o_neg, r_abs[0], r_abs[1], r_abs[2],
                        e_comp[0], e_comp[1], e_comp[2],
                        e_scaled[0], e_scaled[1], e_scaled[2],
                        s_rad[CW], s_rem[CW], d_rem[NDIV][0], d_rem[NDIV][1],
                        d_rem[NDIV][2]};
endmodule
`default_nettype wire

[hdl/vns_checker.sv]
// Port-level assertions for vector3_normalize_scale, attached by bind.
// Depends on vns_pkg and the top level's ports.
`default_nettype none
module vns_checker import vns_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_kind,
   input wire logic                  rsp_valid,
   input wire logic [COMP_WIDTH-1:0] rsp_magnitude,
   input wire logic                  rsp_zero_length,
   input wire logic                  rsp_saturated
);
   localparam int LAT = COMP_WIDTH + FRAC_BITS + 5;

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without item");
   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_magnitude == '0)
      else $error("zero flag with nonzero magnitude");
   a_flags_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> $past(req_kind == KIND_SCALE, LAT) && !rsp_zero_length)
      else $error("saturated flag on normalize item");
endmodule

bind vector3_normalize_scale vns_checker #(
   .FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)
) u_vns_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_magnitude   (rsp_magnitude),
   .rsp_zero_length (rsp_zero_length),
   .rsp_saturated   (rsp_saturated)
);
`default_nettype wire

[dv/vector3_normalize_scale_tb.sv]
// Self-checking bench for vector3_normalize_scale: normalize and scale items,
// predicted in place and compared field by field. Depends on vns_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_scale_tb import vns_pkg::*;;

   localparam int FB = FRAC_BITS_DEF;
   localparam int CW = COMP_WIDTH_DEF;
   localparam int LATENCY = CW + FB + 5;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CW-1:0] magnitude;
      logic [CW-1:0] res_x;
      logic [CW-1:0] res_y;
      logic [CW-1:0] res_z;
      logic          zero_length;
      logic          saturated;
   } vec_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic          req_kind = 1'b0;
   logic [CW-1:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic [CW-1:0] req_scale_factor = '0;
   logic          rsp_valid;
   logic [CW-1:0] rsp_magnitude, rsp_res_x, rsp_res_y, rsp_res_z;
   logic          rsp_zero_length, rsp_saturated;

   vec_result_type pending_results[$];
   int             mismatch_count = 0;
   longint         cycle_count = 0;
   bit             quiet_mode = 1'b0;

   vector3_normalize_scale u_dut (
      .clock, .reset, .start, .busy, .req_kind, .req_comp_x, .req_comp_y,
      .req_comp_z, .req_scale_factor, .rsp_valid, .rsp_magnitude, .rsp_res_x,
      .rsp_res_y, .rsp_res_z, .rsp_zero_length, .rsp_saturated
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [CW:0] abs_of(logic [CW-1:0] v);
      return v[CW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
   endfunction

   function automatic logic [CW-1:0] isqrt(logic [2*CW+2:0] s);
      logic [CW:0]     r;
      logic [CW:0]     c;
      r = '0;
      for (int b = CW; b >= 0; b--) begin
         c = r | ((CW+1)'(1) << b);
         if ((2*CW+3)'(c) * (2*CW+3)'(c) <= s) r = c;
      end
      return r[CW-1:0];
   endfunction

   function automatic vec_result_type predict_vector(kind_type kind, logic [CW-1:0] cx,
         logic [CW-1:0] cy, logic [CW-1:0] cz, logic [CW-1:0] sf);
      vec_result_type  res;
      logic [CW-1:0]   comps[3];
      logic [CW-1:0]   outs[3];
      logic [2*CW+2:0] sum;
      logic [CW:0]     a, ak, lim;
      logic [2*CW+1:0] prod, q;
      logic            neg;
      comps = '{cx, cy, cz};
      sum = '0;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         a = abs_of(comps[i]);
         sum += (2*CW+3)'(a) * (2*CW+3)'(a);
      end
      res.magnitude = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         a = abs_of(comps[i]);
         neg = comps[i][CW-1];
         if (kind == KIND_NORMALIZE) begin
            if (res.magnitude == 0) outs[i] = comps[i];
            else begin
               q = ((2*CW+2)'(a) << FB) / (2*CW+2)'(res.magnitude);
               outs[i] = neg ? CW'(-q) : CW'(q);
            end
         end else begin
            ak = abs_of(sf);
            neg = neg ^ sf[CW-1];
            lim = neg ? (CW+1)'(1) << (CW-1) : ((CW+1)'(1) << (CW-1)) - 1;
            prod = ((2*CW+2)'(a) * (2*CW+2)'(ak)) >> FB;
            if (prod > (2*CW+2)'(lim)) begin
               prod = (2*CW+2)'(lim);
               res.saturated = 1'b1;
            end
            outs[i] = neg ? CW'(-prod) : CW'(prod);
         end
      end
      res.zero_length = (kind == KIND_NORMALIZE) && (res.magnitude == 0);
      res.res_x = outs[0];
      res.res_y = outs[1];
      res.res_z = outs[2];
      return res;
   endfunction

   always @(posedge clock) begin
      vec_result_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_magnitude, rsp_res_x, rsp_res_y, rsp_res_z,
                 rsp_zero_length, rsp_saturated};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: mag %h/%h x %h/%h y %h/%h z %h/%h zl %b/%b sat %b/%b",
                     want.magnitude, got.magnitude, want.res_x, got.res_x,
                     want.res_y, got.res_y, want.res_z, got.res_z,
                     want.zero_length, got.zero_length, want.saturated, got.saturated);
            end
         end
      end
   end

   // Drive one item and hold it until accepted; start is left high afterwards.
   task automatic send_item(kind_type kind, logic [CW-1:0] cx, logic [CW-1:0] cy,
         logic [CW-1:0] cz, logic [CW-1:0] sf);
      if (!quiet_mode && $urandom_range(99) < 11) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_comp_x <= cx;
      req_comp_y <= cy;
      req_comp_z <= cz;
      req_scale_factor <= sf;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_vector(kind, cx, cy, cz, sf));
   endtask

   function automatic logic [CW-1:0] rand_comp();
      case ($urandom_range(5))
         0: return CW'($urandom_range(255));
         1: return -CW'($urandom_range(255));
         2: return {1'b1, {(CW-1){1'b0}}};
         3: return {1'b0, {(CW-1){1'b1}}};
         4: return CW'($urandom_range(32'h3ffff)) - CW'(32'h20000);
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic test_directed_extremes();
      logic [CW-1:0] mn, mx, one;
      mn = {1'b1, {(CW-1){1'b0}}};
      mx = {1'b0, {(CW-1){1'b1}}};
      one = CW'(1) << FB;
      send_item(KIND_NORMALIZE, '0, '0, '0, '0);
      send_item(KIND_SCALE, '0, '0, '0, mx);
      send_item(KIND_NORMALIZE, mn, mn, mn, '0);
      send_item(KIND_NORMALIZE, mx, mx, mx, '0);
      send_item(KIND_NORMALIZE, mn, '0, '0, '0);
      send_item(KIND_NORMALIZE, '0, mx, '0, '0);
      send_item(KIND_NORMALIZE, '0, '0, CW'(-1), '0);
      send_item(KIND_NORMALIZE, CW'(3), CW'(-4), '0, '0);
      send_item(KIND_SCALE, mx, mn, one, mx);
      send_item(KIND_SCALE, mn, mn, mn, mn);
      send_item(KIND_SCALE, mx, mn, CW'(-1), mn);
      send_item(KIND_SCALE, one, -one, mx, one);
      send_item(KIND_SCALE, mn, mx, one, -one);
      send_item(KIND_SCALE, CW'(5), CW'(-7), CW'(9), '1);
      send_item(KIND_SCALE, one << 1, one, mn, one << 1);
      send_item(KIND_NORMALIZE, '1, '1, '1, mn);
   endtask

   task automatic test_random_normalize(int count);
      for (int i = 0; i < count; i++)
         send_item(KIND_NORMALIZE, rand_comp(), rand_comp(), rand_comp(), CW'($urandom));
   endtask

   task automatic test_random_scale(int count);
      for (int i = 0; i < count; i++)
         send_item(KIND_SCALE, rand_comp(), rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic test_back_to_back(int count);
      quiet_mode = 1'b1;
      for (int i = 0; i < count; i++)
         send_item(kind_type'($urandom_range(1)), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp());
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_normalize(700);
      test_back_to_back(400);
      test_random_scale(700);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
hdl/vns_pkg.sv
hdl/vns_front.sv
hdl/vns_sqrt_cell.sv
hdl/vns_div_cell.sv
hdl/vector3_normalize_scale.sv
hdl/vns_checker.sv
dv/vector3_normalize_scale_tb.sv
